// ----- src/ilmd_pkg.sv -----
// Shared types and codes for the interval local maxima detector.
// No dependencies; the front, queue, back, top level and testbench import this package.
`default_nettype none
package ilmd_pkg;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_CHROM_DEC = 3'd1,
		ST_START_DEC = 3'd2,
		ST_NESTED    = 3'd3,
		ST_OVERFLOW  = 3'd4
	} status_t;

	// One classified item handed from the front to the back.
	typedef struct packed {
		logic [15:0] chromosome;
		logic [31:0] start_pos;
		logic [31:0] end_pos;
		logic [31:0] score;
		logic        final_item;
		logic        same_chrom;
		status_t     err;
	} cmd_t;

	typedef struct packed {
		logic [31:0] region_number;
		logic        is_peak;
		status_t     status;
		logic        run_end;
	} res_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_EV_RD,
		BK_EV_CHK,
		BK_CMP,
		BK_POST,
		BK_FL_RD,
		BK_FL_EMIT,
		BK_ERR
	} back_state_t;

endpackage
`default_nettype wire

// ----- src/ilmd_in_if.sv -----
// Input channel: one region per item, valid/ready handshake.
// No dependencies.
`default_nettype none
interface ilmd_in_if;
	logic        valid;
	logic        ready;
	logic [15:0] chromosome;
	logic [31:0] start_pos;
	logic [31:0] end_pos;
	logic signed [31:0] score;
	logic        final_item;

	modport source (output valid, chromosome, start_pos, end_pos, score, final_item,
		input ready);
	modport sink (input valid, chromosome, start_pos, end_pos, score, final_item,
		output ready);
endinterface
`default_nettype wire

// ----- src/ilmd_out_if.sv -----
// Output channel: one resolved region or error per item.
// No dependencies.
`default_nettype none
interface ilmd_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] region_number;
	logic        is_peak;
	logic [2:0]  status;
	logic        run_end;

	modport source (output valid, region_number, is_peak, status, run_end, input ready);
	modport sink (input valid, region_number, is_peak, status, run_end, output ready);
endinterface
`default_nettype wire

// ----- src/ilmd_front.sv -----
// Front: accepts regions, checks sort order, tracks the ordering reference.
// Depends on ilmd_pkg and ilmd_in_if.
`default_nettype none
module ilmd_front (
	input  wire logic  clk,
	input  wire logic  arst_n,
	ilmd_in_if.sink    regions,
	output ilmd_pkg::cmd_t cmd,
	output logic       cmd_valid,
	input  wire logic  cmd_ready
);
	import ilmd_pkg::*;

	logic [15:0] chrom_q;
	logic [31:0] start_q;
	logic [31:0] end_q;
	status_t     err;
	logic        take;

	assign regions.ready = cmd_ready;
	assign cmd_valid     = regions.valid;
	assign take          = regions.valid && cmd_ready;

	always_comb begin
		priority if (regions.chromosome < chrom_q) begin
			err = ST_CHROM_DEC;
		end else if (regions.chromosome == chrom_q && regions.start_pos < start_q) begin
			err = ST_START_DEC;
		end else if (regions.chromosome == chrom_q && regions.end_pos < end_q) begin
			err = ST_NESTED;
		end else begin
			err = ST_OK;
		end
	end

	assign cmd = '{chromosome: regions.chromosome, start_pos: regions.start_pos,
		end_pos: regions.end_pos, score: regions.score, final_item: regions.final_item,
		same_chrom: (regions.chromosome == chrom_q), err: err};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chrom_q <= '0;
			start_q <= '0;
			end_q   <= '0;
		end else if (take) begin
			if (regions.final_item) begin
				chrom_q <= '0;
				start_q <= '0;
				end_q   <= '0;
			end else if (err == ST_OK) begin
				chrom_q <= regions.chromosome;
				start_q <= regions.start_pos;
				end_q   <= regions.end_pos;
			end
		end
	end
endmodule
`default_nettype wire

// ----- src/ilmd_cmd_fifo.sv -----
// Two-entry queue of classified items between front and back.
// Depends on ilmd_pkg.
`default_nettype none
module ilmd_cmd_fifo (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire ilmd_pkg::cmd_t  wr_cmd,
	input  wire logic            wr_valid,
	output logic                 wr_ready,
	output ilmd_pkg::cmd_t       rd_cmd,
	output logic                 rd_valid,
	input  wire logic            rd_ready
);
	import ilmd_pkg::*;

	cmd_t       slot_q [2];
	logic       wp_q;
	logic       rp_q;
	logic [1:0] cnt_q;
	logic       push;
	logic       pop;

	assign wr_ready = (cnt_q != 2'd2);
	assign rd_valid = (cnt_q != 2'd0);
	assign rd_cmd   = slot_q[rp_q];
	assign push     = wr_valid && wr_ready;
	assign pop      = rd_valid && rd_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wp_q] <= wr_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wp_q <= ~wp_q;
			end
			if (pop) begin
				rp_q <= ~rp_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end
endmodule
`default_nettype wire

// ----- src/ilmd_back.sv -----
// Back: pending-region window, eviction, score comparison and result output.
// Depends on ilmd_pkg.
`default_nettype none
module ilmd_back #(
	parameter int DEPTH = 32
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic [31:0]    window_range,
	input  wire ilmd_pkg::cmd_t cmd,
	input  wire logic           cmd_valid,
	output logic                cmd_ready,
	output ilmd_pkg::res_t      res,
	output logic                res_valid,
	input  wire logic           res_ready
);
	import ilmd_pkg::*;

	localparam int IW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int SW = IW + 2;

	function automatic logic [IW-1:0] wrap(input logic [SW-1:0] a);
		logic [SW-1:0] d;
		d = a - SW'(DEPTH);
		wrap = (a >= SW'(DEPTH)) ? d[IW-1:0] : a[IW-1:0];
	endfunction

	back_state_t state_q, state_d;
	cmd_t        c_q;
	status_t     st_q;
	logic [IW-1:0] head_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] k_q;
	logic [31:0]   num_q;
	logic [DEPTH-1:0] beaten_q;
	logic        item_beaten_q;
	logic        hold_v_q;
	res_t        hold_q;
	logic        out_v_q;
	res_t        out_q;

	logic [31:0] mem_end   [DEPTH];
	logic [31:0] mem_score [DEPTH];
	logic [31:0] mem_num   [DEPTH];
	logic [31:0] rd_end_q;
	logic [31:0] rd_score_q;
	logic [31:0] rd_num_q;

	logic [IW-1:0] raddr, tail, cmp_idx;
	logic        slot_free, evict, ld_cmd, emit, pop, ld_hold, clr_hold;
	logic        cmp_step, ins, clr_run, set_ovf, cmp_last;
	res_t        emit_res, head_res;

	assign slot_free = !out_v_q || res_ready;
	assign tail      = wrap(SW'(head_q) + SW'(count_q));
	assign cmp_idx   = wrap(SW'(head_q) + SW'(k_q));
	assign cmp_last  = (k_q + 1'b1) == count_q;
	assign evict     = (count_q != '0) && (!c_q.same_chrom ||
		({1'b0, c_q.start_pos} > ({1'b0, rd_end_q} + {1'b0, window_range})));
	assign head_res  = '{region_number: rd_num_q, is_peak: !beaten_q[head_q],
		status: ST_OK, run_end: 1'b0};

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BK_IDLE: begin
				if (cmd_valid) begin
					priority if (cmd.err != ST_OK && cmd.final_item) begin
						state_d = BK_FL_RD;
					end else if (cmd.err != ST_OK) begin
						state_d = BK_ERR;
					end else begin
						state_d = BK_EV_RD;
					end
				end
			end
			BK_EV_RD: state_d = BK_EV_CHK;
			BK_EV_CHK: begin
				if (!hold_v_q || slot_free) begin
					priority if (evict) begin
						state_d = BK_EV_RD;
					end else if (count_q != '0) begin
						state_d = BK_CMP;
					end else begin
						state_d = BK_POST;
					end
				end
			end
			BK_CMP: begin
				if (cmp_last) begin
					state_d = BK_POST;
				end
			end
			BK_POST: begin
				priority if (c_q.final_item) begin
					state_d = BK_FL_RD;
				end else if (count_q == CW'(DEPTH)) begin
					state_d = BK_ERR;
				end else begin
					state_d = BK_IDLE;
				end
			end
			BK_FL_RD: state_d = BK_FL_EMIT;
			BK_FL_EMIT: begin
				if (slot_free) begin
					state_d = (count_q != '0) ? BK_FL_RD : BK_IDLE;
				end
			end
			BK_ERR: begin
				if (slot_free) begin
					state_d = BK_IDLE;
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		cmd_ready = 1'b0;
		ld_cmd    = 1'b0;
		raddr     = head_q;
		emit      = 1'b0;
		emit_res  = head_res;
		pop       = 1'b0;
		ld_hold   = 1'b0;
		clr_hold  = 1'b0;
		cmp_step  = 1'b0;
		ins       = 1'b0;
		clr_run   = 1'b0;
		set_ovf   = 1'b0;
		unique case (state_q)
			BK_IDLE: begin
				cmd_ready = 1'b1;
				ld_cmd    = cmd_valid;
			end
			BK_EV_CHK: begin
				if (!hold_v_q || slot_free) begin
					if (hold_v_q) begin
						emit     = 1'b1;
						emit_res = hold_q;
						emit_res.run_end = !evict && !c_q.final_item;
					end
					if (evict) begin
						pop     = 1'b1;
						ld_hold = 1'b1;
					end else begin
						clr_hold = 1'b1;
					end
				end
			end
			BK_CMP: begin
				cmp_step = 1'b1;
				raddr    = wrap(SW'(head_q) + SW'(k_q) + SW'(1));
			end
			BK_POST: begin
				if (!c_q.final_item) begin
					if (count_q == CW'(DEPTH)) begin
						set_ovf = 1'b1;
					end else begin
						ins = 1'b1;
					end
				end
			end
			BK_FL_EMIT: begin
				if (slot_free) begin
					emit = 1'b1;
					if (count_q != '0) begin
						pop = 1'b1;
					end else begin
						clr_run = 1'b1;
						emit_res = '{region_number: num_q,
							is_peak: (st_q == ST_OK) && !item_beaten_q,
							status: st_q, run_end: 1'b1};
					end
				end
			end
			BK_ERR: begin
				if (slot_free) begin
					emit     = 1'b1;
					emit_res = '{region_number: num_q, is_peak: 1'b0,
						status: st_q, run_end: 1'b1};
				end
			end
			default: begin
				cmd_ready = 1'b0;
			end
		endcase
	end

	// window storage
	always_ff @(posedge clk) begin
		if (ins) begin
			mem_end[tail]   <= c_q.end_pos;
			mem_score[tail] <= c_q.score;
			mem_num[tail]   <= num_q;
		end
		rd_end_q   <= mem_end[raddr];
		rd_score_q <= mem_score[raddr];
		rd_num_q   <= mem_num[raddr];
		if (ld_cmd) begin
			c_q <= cmd;
		end
		if (ld_hold) begin
			hold_q <= head_res;
		end
		if (emit) begin
			out_q <= emit_res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= BK_IDLE;
			st_q          <= ST_OK;
			head_q        <= '0;
			count_q       <= '0;
			k_q           <= '0;
			num_q         <= '0;
			beaten_q      <= '0;
			item_beaten_q <= 1'b0;
			hold_v_q      <= 1'b0;
			out_v_q       <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ld_cmd) begin
				st_q          <= cmd.err;
				k_q           <= '0;
				item_beaten_q <= 1'b0;
			end
			if (set_ovf) begin
				st_q <= ST_OVERFLOW;
			end
			if (pop) begin
				head_q  <= wrap(SW'(head_q) + SW'(1));
				count_q <= count_q - 1'b1;
			end
			if (ld_hold) begin
				hold_v_q <= 1'b1;
			end else if (clr_hold) begin
				hold_v_q <= 1'b0;
			end
			if (cmp_step) begin
				k_q <= k_q + 1'b1;
				if ($signed(rd_score_q) > $signed(c_q.score)) begin
					item_beaten_q <= 1'b1;
				end else if ($signed(c_q.score) > $signed(rd_score_q)) begin
					beaten_q[cmp_idx] <= 1'b1;
				end
			end
			if (ins) begin
				beaten_q[tail] <= item_beaten_q;
				count_q        <= count_q + 1'b1;
				num_q          <= num_q + 32'd1;
			end
			if (clr_run) begin
				head_q  <= '0;
				count_q <= '0;
				num_q   <= '0;
			end
			if (emit) begin
				out_v_q <= 1'b1;
			end else if (res_ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	assign res       = out_q;
	assign res_valid = out_v_q;
endmodule
`default_nettype wire

// ----- src/interval_local_maxima_detector.sv -----
// Interval local maxima detector. Per item the back evicts the regions that the new start
// has moved past or that lie on another chromosome, compares the item with each region still
// pending through one comparator and inserts it, or on a final item flushes every pending region.
// One item at a time in the back; the front and a two-entry queue take the next ones.
// Reset (arst_n, asynchronous): window empty, run state zero, window_range = 1.
`default_nettype none
module interval_local_maxima_detector #(
	parameter int WINDOW_DEPTH = 32
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	ilmd_in_if.sink          regions,
	ilmd_out_if.source       results,
	input  wire logic        cfg_we,
	input  wire logic [31:0] cfg_wdata
);
	import ilmd_pkg::*;

	logic [31:0] range_q;
	cmd_t        f_cmd, b_cmd;
	logic        f_valid, f_ready, b_valid, b_ready;
	res_t        res;
	logic        res_valid;

	// neighbour range register; the user must write it only while the block is idle; the block does not enforce it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			range_q <= 32'd1;
		end else if (cfg_we) begin
			range_q <= cfg_wdata;
		end
	end

	// front: order checks, classify, hold the ordering reference
	ilmd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.regions   (regions),
		.cmd       (f_cmd),
		.cmd_valid (f_valid),
		.cmd_ready (f_ready)
	);

	// queue so the front keeps accepting while the back works
	ilmd_cmd_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_cmd   (f_cmd),
		.wr_valid (f_valid),
		.wr_ready (f_ready),
		.rd_cmd   (b_cmd),
		.rd_valid (b_valid),
		.rd_ready (b_ready)
	);

	// back: evict, compare, insert or flush, drive the result register
	ilmd_back #(
		.DEPTH (WINDOW_DEPTH)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.window_range (range_q),
		.cmd          (b_cmd),
		.cmd_valid    (b_valid),
		.cmd_ready    (b_ready),
		.res          (res),
		.res_valid    (res_valid),
		.res_ready    (results.ready)
	);

	assign results.valid         = res_valid;
	assign results.region_number = res.region_number;
	assign results.is_peak       = res.is_peak;
	assign results.status        = res.status;
	assign results.run_end       = res.run_end;

`ifndef SYNTHESIS
	a_accept_queued: assert property (@(posedge clk) disable iff (!arst_n)
		regions.valid && regions.ready |=> b_valid)
		else $error("accepted item did not reach the queue");
	a_err_not_peak: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid && results.status != ST_OK |-> !results.is_peak)
		else $error("error result flagged as peak");
	a_err_last: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid && results.status != ST_OK |-> results.run_end)
		else $error("error result not last of its item");
`endif
endmodule
`default_nettype wire

// ----- test/interval_local_maxima_detector_tb.sv -----
// Self-checking regression for the interval local maxima detector.
// Depends on the detector, ilmd_pkg, ilmd_in_if and ilmd_out_if from the RTL sources.
`default_nettype none
module interval_local_maxima_detector_tb;
	import ilmd_pkg::*;

	localparam int DEPTH = 32;
	localparam int WATCHDOG_LIMIT = 20000;

	typedef struct {
		logic [15:0] chromosome;
		logic [31:0] start_pos;
		logic [31:0] end_pos;
		logic [31:0] score;
		logic        final_item;
	} region_t;

	typedef struct {
		logic [31:0] region_number;
		logic        is_peak;
		status_t     status;
		logic        run_end;
	} verdict_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [31:0] cfg_wdata = '0;

	ilmd_in_if regions ();
	ilmd_out_if results ();

	interval_local_maxima_detector #(.WINDOW_DEPTH(DEPTH)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.regions(regions.sink),
		.results(results.source),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	always #4 clk = ~clk;

	// Predictor state: a mirror of the detector's run state and window.
	logic [31:0] gap_limit;
	logic [31:0] win_end[DEPTH];
	logic [31:0] win_score[DEPTH];
	logic [31:0] win_number[DEPTH];
	logic        win_beaten[DEPTH];
	int          win_head, win_count;
	logic [15:0] cur_chrom;
	logic [31:0] last_start, last_end, region_seq;

	region_t  pending_regions[$];
	verdict_t expected_verdicts[$];

	int mismatches = 0;
	int results_seen = 0;
	int peaks_seen = 0;
	int errors_seen = 0;
	int regions_sent = 0;
	bit drive_enable = 1'b0;
	bit hold_sender = 1'b0;
	bit long_stall_req = 1'b0;
	int idle_cycles = 0;

	function automatic int pick_gap();
		int r;
		r = $urandom_range(99);
		if (r < 40) return 0;
		if (r < 90) return $urandom_range(3, 1);
		return $urandom_range(60, 10);
	endfunction

	function automatic void clear_run_state();
		win_head = 0;
		win_count = 0;
		cur_chrom = '0;
		last_start = '0;
		last_end = '0;
		region_seq = '0;
	endfunction

	function automatic void push_verdict(logic [31:0] num, logic peak, status_t st);
		verdict_t v;
		v.region_number = num;
		v.is_peak = peak;
		v.status = st;
		v.run_end = 1'b0;
		expected_verdicts.push_back(v);
	endfunction

	function automatic void retire_oldest();
		push_verdict(win_number[win_head], !win_beaten[win_head], ST_OK);
		win_head = (win_head + 1) % DEPTH;
		win_count--;
	endfunction

	// Work out the verdicts that one accepted region causes.
	function automatic void predict_verdicts(region_t r);
		status_t st;
		bit beaten;
		int idx, prior_count;
		prior_count = expected_verdicts.size();
		st = ST_OK;
		beaten = 1'b0;
		if (r.chromosome < cur_chrom) st = ST_CHROM_DEC;
		else if (r.chromosome == cur_chrom) begin
			if (r.start_pos < last_start) st = ST_START_DEC;
			else if (r.end_pos < last_end) st = ST_NESTED;
		end
		if (st == ST_OK) begin
			// Evict regions that the new start has moved past or that lie on another chromosome.
			while (win_count > 0) begin
				if (r.chromosome == cur_chrom && {1'b0, r.start_pos} <=
						{1'b0, win_end[win_head]} + {1'b0, gap_limit})
					break;
				retire_oldest();
			end
			cur_chrom = r.chromosome;
			last_start = r.start_pos;
			last_end = r.end_pos;
			for (int k = 0; k < win_count; k++) begin
				idx = (win_head + k) % DEPTH;
				if ($signed(win_score[idx]) > $signed(r.score)) beaten = 1'b1;
				else if ($signed(r.score) > $signed(win_score[idx])) win_beaten[idx] = 1'b1;
			end
			if (r.final_item) begin
				while (win_count > 0) retire_oldest();
				push_verdict(region_seq, !beaten, ST_OK);
			end else if (win_count >= DEPTH) begin
				st = ST_OVERFLOW;
			end else begin
				idx = (win_head + win_count) % DEPTH;
				win_end[idx] = r.end_pos;
				win_score[idx] = r.score;
				win_number[idx] = region_seq;
				win_beaten[idx] = beaten;
				win_count++;
				region_seq++;
			end
		end else if (r.final_item) begin
			while (win_count > 0) retire_oldest();
		end
		if (st != ST_OK) push_verdict(region_seq, 1'b0, st);
		if (r.final_item) clear_run_state();
		if (expected_verdicts.size() > prior_count)
			expected_verdicts[expected_verdicts.size() - 1].run_end = 1'b1;
	endfunction

	// Driver: offer pending regions with random gaps; hold valid across items.
	int send_gap = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regions.valid <= 1'b0;
			regions.chromosome <= '0;
			regions.start_pos <= '0;
			regions.end_pos <= '0;
			regions.score <= '0;
			regions.final_item <= 1'b0;
			send_gap <= 0;
		end else begin
			if (regions.valid && regions.ready) begin
				predict_verdicts(pending_regions.pop_front());
				regions_sent++;
			end
			if (regions.valid && !regions.ready) begin
				// hold the offered item
			end else if (send_gap > 0) begin
				send_gap <= send_gap - 1;
				regions.valid <= 1'b0;
			end else if (drive_enable && !hold_sender && pending_regions.size() > 0) begin
				region_t nx;
				nx = pending_regions[0];
				regions.valid <= 1'b1;
				regions.chromosome <= nx.chromosome;
				regions.start_pos <= nx.start_pos;
				regions.end_pos <= nx.end_pos;
				regions.score <= nx.score;
				regions.final_item <= nx.final_item;
				if ($urandom_range(3) == 0) send_gap <= pick_gap();
			end else begin
				regions.valid <= 1'b0;
			end
		end
	end

	// Monitor: random ready, a long hold-off on request, field-wise checks.
	int stall_left = 0;
	int long_left = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			results.ready <= 1'b0;
			stall_left <= 0;
			long_left <= 0;
		end else begin
			if (results.valid && results.ready) begin
				verdict_t got, want;
				got.region_number = results.region_number;
				got.is_peak = results.is_peak;
				got.status = status_t'(results.status);
				got.run_end = results.run_end;
				results_seen++;
				if (got.is_peak) peaks_seen++;
				if (got.status != ST_OK) errors_seen++;
				if (expected_verdicts.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result: number %0d peak %0b status %0d end %0b",
							got.region_number, got.is_peak, got.status, got.run_end);
				end else begin
					want = expected_verdicts.pop_front();
					if (got.region_number !== want.region_number ||
							got.is_peak !== want.is_peak ||
							got.status !== want.status || got.run_end !== want.run_end) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: expected number %0d peak %0b status %0d end %0b, %s",
								want.region_number, want.is_peak, want.status, want.run_end,
								$sformatf("got number %0d peak %0b status %0d end %0b",
									got.region_number, got.is_peak, got.status, got.run_end));
					end
				end
			end
			if (long_stall_req && long_left == 0) begin
				long_left <= 300;
				long_stall_req <= 1'b0;
				results.ready <= 1'b0;
			end else if (long_left > 0) begin
				long_left <= long_left - 1;
				results.ready <= (long_left == 1);
			end else if (stall_left > 0) begin
				stall_left <= stall_left - 1;
				results.ready <= 1'b0;
			end else begin
				results.ready <= 1'b1;
				if ($urandom_range(4) == 0) stall_left <= pick_gap();
			end
		end
	end

	// Watchdog: count cycles in which neither side accepts an item.
	always @(posedge clk) begin
		if ((regions.valid && regions.ready) || (results.valid && results.ready))
			idle_cycles <= 0;
		else if (arst_n)
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("timeout: %0d verdicts still owed", expected_verdicts.size());
			$display("interval_local_maxima_detector regression: fail");
			$finish;
		end
	end

	function automatic void add_region(logic [15:0] c, logic [31:0] s, logic [31:0] e,
			logic [31:0] sc, logic fin);
		region_t r;
		r.chromosome = c;
		r.start_pos = s;
		r.end_pos = e;
		r.score = sc;
		r.final_item = fin;
		pending_regions.push_back(r);
	endfunction

	// Build a well-formed run with random content, sometimes broken on purpose.
	function automatic void add_random_run(int len, int max_step);
		logic [15:0] c;
		logic [31:0] s, e, sc;
		int r;
		c = 16'($urandom_range(3));
		s = $urandom_range(1000);
		e = s + $urandom_range(20);
		for (int i = 0; i < len; i++) begin
			r = $urandom_range(99);
			if (r < 6) begin
				// chromosome switch, occasionally to a high id
				c = (r < 2) ? 16'(16'hFFFF - $urandom_range(3)) :
					16'(c + $urandom_range(2, 1));
				s = $urandom_range(100);
				e = s + $urandom_range(30);
			end else begin
				s = s + $urandom_range(max_step);
				e = (e > s ? e : s) + $urandom_range(max_step);
			end
			sc = ($urandom_range(3) == 0) ? $urandom : 32'($urandom_range(6)) - 3;
			r = $urandom_range(99);
			if (r < 3 && c > 0) add_region(16'(c - 16'd1), s, e, sc, 1'b0);
			else if (r < 6 && s > 0) add_region(c, s - 1, e, sc, 1'b0);
			else if (r < 9 && e > 0) add_region(c, s, e - 1, sc, 1'b0);
			else if (r < 11) add_region(16'($urandom), $urandom, $urandom, $urandom, 1'b0);
			else add_region(c, s, e, sc, 1'b0);
		end
		add_region(c, s + $urandom_range(max_step), e + max_step, $urandom, 1'b1);
	endfunction

	task automatic wait_drained();
		while (pending_regions.size() > 0 || regions.valid || expected_verdicts.size() > 0)
			@(posedge clk);
		// let any item with no verdict clear the block
		repeat (80) @(posedge clk);
	endtask

	task automatic set_gap_limit(logic [31:0] value);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		gap_limit = value;
	endtask

	initial begin
		logic [31:0] ranges[5];
		ranges = '{32'd0, 32'd5, 32'hFFFF_FFFF, 32'd1000, 32'hAAAA_5555};
		gap_limit = 32'd1;
		clear_run_state();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		drive_enable = 1'b1;

		// Directed: reset range, field extremes, ties, each error code, lone final.
		add_region(16'd0, 32'd0, 32'd0, 32'h8000_0000, 1'b0);
		add_region(16'd0, 32'd1, 32'd5, 32'h7FFF_FFFF, 1'b0);
		add_region(16'd0, 32'd3, 32'd9, 32'h7FFF_FFFF, 1'b0);
		add_region(16'd0, 32'd2, 32'd9, 32'd0, 1'b0);
		add_region(16'd0, 32'd3, 32'd8, 32'd0, 1'b0);
		add_region(16'd0, 32'd11, 32'd12, 32'hFFFF_0000, 1'b0);
		add_region(16'd0, 32'd20, 32'd30, 32'd5, 1'b0);
		add_region(16'd2, 32'd0, 32'd1, 32'd1, 1'b0);
		add_region(16'd1, 32'd5, 32'd6, 32'd1, 1'b0);
		add_region(16'hFFFF, 32'hFFFF_FFFE, 32'hFFFF_FFFF, 32'd7, 1'b0);
		add_region(16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd7, 1'b0);
		add_region(16'hFFFF, 32'd0, 32'd0, 32'd9, 1'b1);
		add_region(16'd0, 32'd4, 32'd4, 32'd3, 1'b1);
		add_region(16'd0, 32'd0, 32'd0, 32'd0, 1'b1);
		// Overflow: 34 overlapping regions on one chromosome, then flush.
		for (int i = 0; i < 34; i++) add_region(16'd3, 32'd10, 32'd100, 32'(i % 5), 1'b0);
		add_region(16'd3, 32'd10, 32'd100, 32'd2, 1'b1);
		wait_drained();

		// Random runs under each range setting, extremes included.
		foreach (ranges[i]) begin
			set_gap_limit(ranges[i]);
			for (int n = 0; n < 3; n++) add_random_run($urandom_range(12, 2), 40);
			if (i == 1) begin
				// Fill the window while the receiver holds off.
				long_stall_req = 1'b1;
				add_random_run(36, 2);
			end
			if (i == 3) begin
				// Once every verdict has arrived, queue a run while the sender is paused.
				wait_drained();
				hold_sender = 1'b1;
				add_random_run(6, 3);
				repeat (20) @(posedge clk);
				hold_sender = 1'b0;
			end
			wait_drained();
		end
		set_gap_limit(32'd1);
		add_random_run(10, 3);
		wait_drained();

		$display("covered %0d regions, %0d verdicts (%0d peaks, %0d error reports)",
			regions_sent, results_seen, peaks_seen, errors_seen);
		$display("range settings 0, 1, 5, 1000, 0xAAAA5555 and all ones; %0d mismatches",
			mismatches);
		if (mismatches == 0)
			$display("interval_local_maxima_detector regression: pass");
		else
			$display("interval_local_maxima_detector regression: fail");
		$finish;
	end
endmodule
`default_nettype wire
